FILE: src/sli_pkg.sv
// Shared types and constants for the sorted insertion list.
package sli_pkg;

  // Default list capacity.
  localparam int DEPTH_DEFAULT = 16;

  // Fixed field widths of the command and result transactions.
  localparam int CMD_W    = 2;
  localparam int WEIGHT_W = 16;
  localparam int TAG_W    = 16;
  localparam int POS_W    = 4;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;
  localparam int WHERE_W  = 4;

  // Command codes.
  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_READ   = 2'd2
  } cmd_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_NO_POS = 2'd2
  } status_t;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_INS,
    S_FETCH,
    S_SHIFT
  } state_t;

  // One stored list entry.
  typedef struct packed {
    logic [WEIGHT_W-1:0] weight;
    logic                is_cat;
    logic [TAG_W-1:0]    tag;
  } entry_t;

endpackage

FILE: src/sli_ram.sv
// Entry memory: one write port and one registered read port.
module sli_ram #(
  parameter int DEPTH = sli_pkg::DEPTH_DEFAULT
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [$clog2(DEPTH)-1:0]     waddr,
  input  sli_pkg::entry_t              wdata,
  input  logic [$clog2(DEPTH)-1:0]     raddr,
  output sli_pkg::entry_t              rdata
);
  import sli_pkg::*;

  entry_t mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; read data follows the address in the next cycle.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: src/sorted_list_insert_remove.sv
// Top level of the sorted insertion list: controller, count and result registers.
//
// Keeps up to DEPTH entries (weight, kind, tag) in ascending weight order in a
// single-port-read, single-port-write memory. A command transaction is taken
// when start is high and busy is low; in_command selects insert, remove at
// in_position or read at in_position. Every command gives exactly one result,
// shown for one cycle with out_valid high; the receiver cannot stall it.
//
// A full-list insert, a bad position or an unused command answers in the
// cycle after the start. An insert walks back from the tail, moving one
// entry up per cycle. A read fetches the addressed entry; a remove then
// moves each entry above it down, one entry per cycle. The one memory
// write port sets that pace. Busy is high for the whole walk; the next
// command may start in the cycle its result is shown.
//
// Reset clears the entry count and the controller; memory contents are not
// cleared, since no entry at or beyond the count is ever used.
module sorted_list_insert_remove #(
  parameter int DEPTH = sli_pkg::DEPTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [sli_pkg::CMD_W-1:0]     in_command,
  input  logic [sli_pkg::WEIGHT_W-1:0]  in_weight,
  input  logic                          in_is_cat,
  input  logic [sli_pkg::TAG_W-1:0]     in_tag,
  input  logic [sli_pkg::POS_W-1:0]     in_position,
  output logic                          out_valid,
  output logic [sli_pkg::STATUS_W-1:0]  out_status,
  output logic [sli_pkg::COUNT_W-1:0]   out_count,
  output logic [sli_pkg::WHERE_W-1:0]   out_where,
  output logic [sli_pkg::WEIGHT_W-1:0]  out_weight,
  output logic                          out_is_cat,
  output logic [sli_pkg::TAG_W-1:0]     out_tag
);
  import sli_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam int CMP_W = (SUM_W > POS_W) ? SUM_W : POS_W;

  // Control and held command registers.
  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [CMD_W-1:0]    cmd_r, cmd_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  entry_t              new_r, new_nxt;
  entry_t              rm_r, rm_nxt;

  // Result registers.
  logic                out_valid_r, out_valid_nxt;
  status_t             out_status_r, out_status_nxt;
  logic [COUNT_W-1:0]  out_count_r;
  logic [WHERE_W-1:0]  out_where_r, out_where_nxt;
  entry_t              out_entry_r, out_entry_nxt;

  // Memory port signals.
  logic                mem_we;
  logic [IDX_W-1:0]    mem_waddr;
  entry_t              mem_wdata;
  logic [IDX_W-1:0]    mem_raddr;
  entry_t              mem_rdata;

  // Walk helpers.
  logic                accept;
  logic                full;
  logic                pos_ok;
  logic                passes;
  logic [SUM_W-1:0]    idx_plus1;
  logic [SUM_W-1:0]    idx_plus2;

  sli_ram #(
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign accept    = start && (state_r == S_IDLE);
  assign full      = (count_r == CNT_W'(DEPTH));
  assign pos_ok    = (CMP_W'(in_position) < CMP_W'(count_r));
  assign idx_plus1 = SUM_W'(idx_r) + SUM_W'(1);
  assign idx_plus2 = SUM_W'(idx_r) + SUM_W'(2);

  // The new entry passes stored lighter entries and equal-weight cats.
  assign passes = (mem_rdata.weight < new_r.weight) ||
                  ((mem_rdata.weight == new_r.weight) && mem_rdata.is_cat);

  // Next state, memory control and result.
  // Walks read two addresses ahead of the address written, moving away from it,
  // so a read never meets a write still in flight to the same entry.
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    cmd_nxt        = cmd_r;
    pos_nxt        = pos_r;
    new_nxt        = new_r;
    rm_nxt         = rm_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_where_nxt  = out_where_r;
    out_entry_nxt  = out_entry_r;
    mem_we         = 1'b0;
    mem_waddr      = idx_r;
    mem_wdata      = mem_rdata;
    mem_raddr      = IDX_W'(idx_r - IDX_W'(2));

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_nxt        = in_command;
          pos_nxt        = in_position;
          new_nxt.weight = in_weight;
          new_nxt.is_cat = in_is_cat;
          new_nxt.tag    = in_tag;
          out_entry_nxt  = '0;
          case (in_command)
            CMD_INSERT: begin
              if (full) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_FULL;
                out_where_nxt  = '0;
              end else begin
                // Start at the tail; the first read is the last stored entry.
                idx_nxt   = IDX_W'(count_r);
                mem_raddr = IDX_W'(count_r - CNT_W'(1));
                state_nxt = S_INS;
              end
            end
            CMD_REMOVE, CMD_READ: begin
              if (!pos_ok) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_NO_POS;
                out_where_nxt  = in_position;
              end else begin
                idx_nxt   = IDX_W'(in_position);
                mem_raddr = IDX_W'(in_position);
                state_nxt = S_FETCH;
              end
            end
            default: begin
              // Unused command code: answer with an empty ok result.
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_OK;
              out_where_nxt  = '0;
            end
          endcase
        end
      end

      S_INS: begin
        // Read data holds the entry just below the open slot.
        mem_we = 1'b1;
        if ((idx_r == '0) || passes) begin
          mem_wdata      = new_r;
          count_nxt      = count_r + CNT_W'(1);
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_where_nxt  = WHERE_W'(idx_r);
          out_entry_nxt  = '0;
          state_nxt      = S_IDLE;
        end else begin
          mem_wdata = mem_rdata;
          idx_nxt   = idx_r - IDX_W'(1);
        end
      end

      S_FETCH: begin
        // Read data holds the addressed entry.
        rm_nxt    = mem_rdata;
        mem_raddr = IDX_W'(idx_plus1);
        if ((cmd_r == CMD_REMOVE) && (idx_plus1 < SUM_W'(count_r))) begin
          state_nxt = S_SHIFT;
        end else begin
          if (cmd_r == CMD_REMOVE) begin
            count_nxt = count_r - CNT_W'(1);
          end
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_where_nxt  = pos_r;
          out_entry_nxt  = mem_rdata;
          state_nxt      = S_IDLE;
        end
      end

      S_SHIFT: begin
        // Move the entry above down into the gap.
        mem_we    = 1'b1;
        mem_wdata = mem_rdata;
        idx_nxt   = IDX_W'(idx_plus1);
        mem_raddr = IDX_W'(idx_plus2);
        if (idx_plus2 >= SUM_W'(count_r)) begin
          count_nxt      = count_r - CNT_W'(1);
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_where_nxt  = pos_r;
          out_entry_nxt  = rm_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    cmd_r        <= cmd_nxt;
    pos_r        <= pos_nxt;
    new_r        <= new_nxt;
    rm_r         <= rm_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= COUNT_W'(count_nxt);
    out_where_r  <= out_where_nxt;
    out_entry_r  <= out_entry_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_count  = out_count_r;
  assign out_where  = out_where_r;
  assign out_weight = out_entry_r.weight;
  assign out_is_cat = out_entry_r.is_cat;
  assign out_tag    = out_entry_r.tag;

  // The stored count never exceeds the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count above capacity");

  // A result only appears once the controller is back at rest.
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while a walk is running");

  // A dropped insert reports a full list.
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_FULL)) |-> (out_count == COUNT_W'(DEPTH)))
    else $error("full status with list not full");

  // A missing position lies at or beyond the reported count.
  a_no_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_NO_POS)) |->
      ({1'b0, out_where} >= out_count))
    else $error("position reported missing but present");

endmodule

FILE: dv/sorted_list_insert_remove_check.sv
// Checker for the sorted insertion list: watches both channels, predicts and compares results.
`timescale 1ns / 1ps

module sorted_list_insert_remove_check
  import sli_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  logic [CMD_W-1:0]    in_command,
  input  logic [WEIGHT_W-1:0] in_weight,
  input  logic                in_is_cat,
  input  logic [TAG_W-1:0]    in_tag,
  input  logic [POS_W-1:0]    in_position,
  input  logic                out_valid,
  input  logic [STATUS_W-1:0] out_status,
  input  logic [COUNT_W-1:0]  out_count,
  input  logic [WHERE_W-1:0]  out_where,
  input  logic [WEIGHT_W-1:0] out_weight,
  input  logic                out_is_cat,
  input  logic [TAG_W-1:0]    out_tag,
  output int                  fail_count,
  output int                  pending
);

  localparam int DEPTH = DEPTH_DEFAULT;

  // One predicted result transaction.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
    logic [WHERE_W-1:0]  slot;
    logic [WEIGHT_W-1:0] weight;
    logic                is_cat;
    logic [TAG_W-1:0]    tag;
  } list_answer_t;

  // Shadow copy of the list contents and occupancy.
  entry_t       shadow_list [DEPTH];
  int unsigned  shadow_total;
  list_answer_t answers_due [$];

  // Apply one command to the shadow list and return the result it must produce.
  function automatic list_answer_t apply_list_command(
    input logic [CMD_W-1:0]    cmd,
    input logic [WEIGHT_W-1:0] weight,
    input logic                is_cat,
    input logic [TAG_W-1:0]    tag,
    input logic [POS_W-1:0]    position
  );
    list_answer_t answer;
    int unsigned  idx;
    answer = '0;
    answer.status = ST_OK;
    case (cmd)
      CMD_INSERT: begin
        if (shadow_total >= DEPTH) begin
          answer.status = ST_FULL;
        end else begin
          // Pass lighter entries and cats of equal weight; land before the first dog.
          idx = 0;
          while (idx < shadow_total &&
                 (shadow_list[idx].weight < weight ||
                  (shadow_list[idx].weight == weight && shadow_list[idx].is_cat)))
            idx++;
          for (int unsigned j = shadow_total; j > idx; j--)
            shadow_list[j] = shadow_list[j-1];
          shadow_list[idx] = '{weight: weight, is_cat: is_cat, tag: tag};
          shadow_total++;
          answer.slot = idx[WHERE_W-1:0];
        end
      end
      CMD_REMOVE, CMD_READ: begin
        answer.slot = position;
        if (position >= shadow_total) begin
          answer.status = ST_NO_POS;
        end else begin
          answer.weight = shadow_list[position].weight;
          answer.is_cat = shadow_list[position].is_cat;
          answer.tag    = shadow_list[position].tag;
          // A remove closes the gap behind the taken entry.
          if (cmd == CMD_REMOVE) begin
            for (int unsigned j = position; j + 1 < shadow_total; j++)
              shadow_list[j] = shadow_list[j+1];
            shadow_total--;
          end
        end
      end
      default: begin
        // The unused command leaves the list alone; all fields but the count are zero.
      end
    endcase
    answer.count = shadow_total[COUNT_W-1:0];
    return answer;
  endfunction

  // Report one field that differs from its prediction.
  task automatic compare_field(input string field, input logic [15:0] want,
                               input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      fail_count++;
    end
  endtask

  // Results are matched first, then the command transaction of the same edge is predicted.
  always @(posedge clk) begin
    list_answer_t due;
    if (!rst_n) begin
      shadow_total = 0;
      answers_due.delete();
      pending <= 0;
    end else begin
      if (out_valid) begin
        if (answers_due.size() == 0) begin
          $error("result transaction with no command outstanding (status %0d)", out_status);
          fail_count++;
        end else begin
          due = answers_due.pop_front();
          compare_field("out_status", 16'(due.status), 16'(out_status));
          compare_field("out_count",  16'(due.count),  16'(out_count));
          compare_field("out_where",  16'(due.slot),   16'(out_where));
          compare_field("out_weight", due.weight,      out_weight);
          compare_field("out_is_cat", 16'(due.is_cat), 16'(out_is_cat));
          compare_field("out_tag",    due.tag,         out_tag);
        end
      end
      if (start && !busy)
        answers_due.push_back(apply_list_command(in_command, in_weight, in_is_cat,
                                                 in_tag, in_position));
      pending <= answers_due.size();
    end
  end

endmodule

FILE: dv/sorted_list_insert_remove_test.sv
// Testbench top for the sorted insertion list: clock, reset, command stimulus and verdict.
`timescale 1ns / 1ps

module sorted_list_insert_remove_test;
  import sli_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_COUNT    = 12;
  localparam int PHASE_ITEMS    = 36;

  typedef enum int {PH_GROW, PH_MIXED, PH_SHRINK} phase_kind_t;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [CMD_W-1:0]    in_command;
  logic [WEIGHT_W-1:0] in_weight;
  logic                in_is_cat;
  logic [TAG_W-1:0]    in_tag;
  logic [POS_W-1:0]    in_position;
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [COUNT_W-1:0]  out_count;
  logic [WHERE_W-1:0]  out_where;
  logic [WEIGHT_W-1:0] out_weight;
  logic                out_is_cat;
  logic [TAG_W-1:0]    out_tag;
  int                  fail_count;
  int                  pending;
  int                  idle_cycles;
  bit                  gapless;

  sorted_list_insert_remove i_dut (
    .clk, .rst_n, .start, .busy,
    .in_command, .in_weight, .in_is_cat, .in_tag, .in_position,
    .out_valid, .out_status, .out_count, .out_where, .out_weight, .out_is_cat, .out_tag
  );

  sorted_list_insert_remove_check i_check (
    .clk, .rst_n, .start, .busy,
    .in_command, .in_weight, .in_is_cat, .in_tag, .in_position,
    .out_valid, .out_status, .out_count, .out_where, .out_weight, .out_is_cat, .out_tag,
    .fail_count, .pending
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // The run ends if no transaction moves on either channel for too long.
  initial idle_cycles = 0;
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("sorted_list_insert_remove: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Mostly short pauses between commands, a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (gapless || r < 45) return 0;
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 20);
    return $urandom_range(25, 60);
  endfunction

  // Weights cluster on a few values so that ties are common.
  function automatic logic [WEIGHT_W-1:0] pick_weight();
    case ($urandom_range(0, 3))
      0: return WEIGHT_W'($urandom_range(0, 3));
      1: return 16'hFFFF - WEIGHT_W'($urandom_range(0, 2));
      2: return {8'($urandom_range(0, 3)), 8'h00};
      default: return WEIGHT_W'($urandom);
    endcase
  endfunction

  // Low positions are favored so that removes and reads hit on short lists.
  function automatic logic [POS_W-1:0] pick_position();
    if ($urandom_range(0, 1) == 0) return POS_W'($urandom_range(0, 3));
    return POS_W'($urandom_range(0, 15));
  endfunction

  // Present one command transaction and hold it until the block takes it.
  task automatic issue_command(input logic [CMD_W-1:0] cmd, input logic [WEIGHT_W-1:0] weight,
                               input logic is_cat, input logic [TAG_W-1:0] tag,
                               input logic [POS_W-1:0] position);
    int gap;
    in_command  <= cmd;
    in_weight   <= weight;
    in_is_cat   <= is_cat;
    in_tag      <= tag;
    in_position <= position;
    start       <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    phase_kind_t kind;
    int          r;
    logic [CMD_W-1:0] cmd;

    rst_n       <= 1'b0;
    start       <= 1'b0;
    in_command  <= CMD_INSERT;
    in_weight   <= '0;
    in_is_cat   <= 1'b0;
    in_tag      <= '0;
    in_position <= '0;
    gapless     = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty list, unused command, ties of both kinds, extreme weights and edges.
    issue_command(CMD_READ,   16'h0000, 1'b0, 16'h0000, 4'd0);
    issue_command(CMD_REMOVE, 16'h0000, 1'b0, 16'h0000, 4'd15);
    issue_command(CMD_UNUSED, 16'hFFFF, 1'b1, 16'hFFFF, 4'd15);
    issue_command(CMD_INSERT, 16'h1234, 1'b0, 16'hFFFF, 4'd0);
    issue_command(CMD_INSERT, 16'h1234, 1'b1, 16'h0001, 4'd0);
    issue_command(CMD_INSERT, 16'h1234, 1'b0, 16'h0002, 4'd0);
    issue_command(CMD_INSERT, 16'h1234, 1'b1, 16'h0003, 4'd0);
    issue_command(CMD_INSERT, 16'h0000, 1'b1, 16'h0000, 4'd0);
    issue_command(CMD_INSERT, 16'hFFFF, 1'b0, 16'hA5A5, 4'd0);
    issue_command(CMD_INSERT, 16'hFFFF, 1'b1, 16'h5A5A, 4'd0);
    issue_command(CMD_READ,   16'h0000, 1'b0, 16'h0000, 4'd0);
    issue_command(CMD_READ,   16'h0000, 1'b0, 16'h0000, 4'd6);
    issue_command(CMD_READ,   16'h0000, 1'b0, 16'h0000, 4'd7);
    issue_command(CMD_REMOVE, 16'h0000, 1'b0, 16'h0000, 4'd6);
    issue_command(CMD_REMOVE, 16'h0000, 1'b0, 16'h0000, 4'd0);
    issue_command(CMD_REMOVE, 16'h0000, 1'b0, 16'h0000, 4'd2);
    issue_command(CMD_READ,   16'h0000, 1'b0, 16'h0000, 4'd15);

    // Random: phases that fill the list past full, drain it past empty, or mix.
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      kind    = phase_kind_t'(phase % 3);
      gapless = ($urandom_range(0, 2) == 0);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        r = $urandom_range(0, 99);
        case (kind)
          PH_GROW:  cmd = (r < 75) ? CMD_INSERT : (r < 87) ? CMD_REMOVE : CMD_READ;
          PH_SHRINK: cmd = (r < 15) ? CMD_INSERT : (r < 80) ? CMD_REMOVE : CMD_READ;
          default:  cmd = (r < 40) ? CMD_INSERT : (r < 70) ? CMD_REMOVE : CMD_READ;
        endcase
        if (r == 99) cmd = CMD_UNUSED;
        issue_command(cmd, pick_weight(), 1'($urandom), TAG_W'($urandom), pick_position());
      end
    end
    start <= 1'b0;

    // Drain outstanding results, then give stray results time to show up.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("sorted_list_insert_remove: match");
    end else begin
      $display("sorted_list_insert_remove: mismatch");
    end
    $finish;
  end

endmodule

FILE: files.f
src/sli_pkg.sv
src/sli_ram.sv
src/sorted_list_insert_remove.sv
dv/sorted_list_insert_remove_check.sv
dv/sorted_list_insert_remove_test.sv
